// ===== hdl/sirad_pkg.sv =====
package sirad_pkg;

    // alphabet store
    localparam int unsigned MAX_SYMBOLS = 128;
    localparam int unsigned SYM_AW      = $clog2(MAX_SYMBOLS);

    // digit stack: a 32-bit magnitude in radix 2 or more needs at most 32 digits
    localparam int unsigned NUM_W       = 32;
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
    localparam int unsigned DIGIT_W     = 7;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned LEN_W       = 8;

    // divider retires this many quotient bits per cycle
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned DIV_STEPS     = NUM_W / BITS_PER_STEP;
    localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

    // one flag per 7-bit character code for the repeat check
    localparam int unsigned SEEN_BITS = 128;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;
    localparam logic [LEN_W-1:0]  MIN_BASE   = 8'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

endpackage

// ===== hdl/sirad_ram.sv =====
module sirad_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/signed_integer_to_radix_digits_core.sv =====
// load item: written in the cycle it is accepted, busy stays low, no result.
// convert item: a read state and a check state per alphabet symbol (one alphabet port),
// then the 4-bit-per-cycle divider for each digit, then a stack read, an alphabet
// read and a strobe per emitted digit; results are strobed from an output register
// in the cycle after they are formed, receiver cannot stall.
// synchronous active-low reset returns the sequencer to idle and base_length to 0.
module signed_integer_to_radix_digits_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_base_length_we,
    input  logic [sirad_pkg::LEN_W-1:0]            i_base_length,
    input  logic                                   i_cmd,
    input  logic [sirad_pkg::SYM_AW-1:0]           i_symbol_index,
    input  logic [sirad_pkg::CHAR_W-1:0]           i_symbol_code,
    input  logic signed [sirad_pkg::NUM_W-1:0]     i_number,
    output logic                                   o_result_valid,
    output logic [sirad_pkg::CHAR_W-1:0]           o_char_code,
    output logic                                   o_base_ok,
    output logic                                   o_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHK_RD = 3'd1;
    localparam logic [2:0] ST_CHK_EV = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT_A  = 3'd4;
    localparam logic [2:0] ST_OUT_B  = 3'd5;
    localparam logic [2:0] ST_OUT_C  = 3'd6;

    logic [2:0]                          r_state, n_state;
    logic [sirad_pkg::LEN_W-1:0]         r_base_length;
    logic [sirad_pkg::SYM_AW-1:0]        r_idx, n_idx;
    logic [sirad_pkg::SEEN_BITS-1:0]     r_seen, n_seen;
    logic [sirad_pkg::STEP_W-1:0]        r_step, n_step;
    logic [sirad_pkg::STACK_AW-1:0]      r_ptr, n_ptr;
    logic                                r_out_valid, n_out_valid;
    logic                                r_neg, n_neg;
    logic [sirad_pkg::NUM_W-1:0]         r_q, n_q;
    logic [sirad_pkg::DIGIT_W-1:0]       r_rem, n_rem;
    logic [sirad_pkg::CHAR_W-1:0]        r_char, n_char;
    logic                                r_ok, n_ok;
    logic                                r_last, n_last;

    logic                                w_accept;
    logic [sirad_pkg::NUM_W-1:0]         w_num;
    logic [sirad_pkg::NUM_W-1:0]         w_mag;
    logic                                w_alpha_we;
    logic [sirad_pkg::SYM_AW-1:0]        w_alpha_raddr;
    logic [sirad_pkg::CHAR_W-1:0]        w_alpha_rdata;
    logic                                w_stack_we;
    logic [sirad_pkg::DIGIT_W-1:0]       w_stack_rdata;
    logic [sirad_pkg::NUM_W-1:0]         w_div_q;
    logic [sirad_pkg::DIGIT_W-1:0]       w_div_rem;
    logic                                w_sym_bad;
    logic                                w_len_bad;
    logic                                w_last_sym;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_num    = i_number;
    assign w_mag    = w_num[sirad_pkg::NUM_W-1] ? (~w_num + 32'd1) : w_num;

    assign w_alpha_we = w_accept && (i_cmd == sirad_pkg::CMD_LOAD);

    sirad_ram #(
        .WIDTH (sirad_pkg::CHAR_W),
        .DEPTH (sirad_pkg::MAX_SYMBOLS)
    ) u_alphabet (
        .i_clk   (i_clk),
        .i_we    (w_alpha_we),
        .i_waddr (i_symbol_index),
        .i_wdata (i_symbol_code),
        .i_raddr (w_alpha_raddr),
        .o_rdata (w_alpha_rdata)
    );

    sirad_ram #(
        .WIDTH (sirad_pkg::DIGIT_W),
        .DEPTH (sirad_pkg::STACK_DEPTH)
    ) u_digit_stack (
        .i_clk   (i_clk),
        .i_we    (w_stack_we),
        .i_waddr (r_ptr),
        .i_wdata (w_div_rem),
        .i_raddr (r_ptr),
        .o_rdata (w_stack_rdata)
    );

    // restoring division, several quotient bits per cycle; remainder stays below radix
    always_comb begin
        logic [sirad_pkg::DIGIT_W:0]   v_rem2;
        logic [sirad_pkg::DIGIT_W-1:0] v_rem;
        logic [sirad_pkg::NUM_W-1:0]   v_q;
        v_rem = r_rem;
        v_q   = r_q;
        for (int k = 0; k < sirad_pkg::BITS_PER_STEP; k++) begin
            v_rem2 = {v_rem, v_q[sirad_pkg::NUM_W-1]};
            if (v_rem2 >= r_base_length) begin
                v_rem = sirad_pkg::DIGIT_W'(v_rem2 - r_base_length);
                v_q   = {v_q[sirad_pkg::NUM_W-2:0], 1'b1};
            end else begin
                v_rem = v_rem2[sirad_pkg::DIGIT_W-1:0];
                v_q   = {v_q[sirad_pkg::NUM_W-2:0], 1'b0};
            end
        end
        w_div_q   = v_q;
        w_div_rem = v_rem;
    end

    assign w_len_bad = (r_base_length < sirad_pkg::MIN_BASE) ||
                       (r_base_length > sirad_pkg::LEN_W'(sirad_pkg::MAX_SYMBOLS));

    assign w_sym_bad = (w_alpha_rdata == sirad_pkg::CHAR_PLUS) ||
                       (w_alpha_rdata == sirad_pkg::CHAR_MINUS) ||
                       (w_alpha_rdata < sirad_pkg::CHAR_LOW) ||
                       (w_alpha_rdata > sirad_pkg::CHAR_HIGH) ||
                       r_seen[w_alpha_rdata[6:0]];

    assign w_last_sym = ({1'b0, r_idx} == sirad_pkg::LEN_W'(r_base_length - 8'd1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_seen      = r_seen;
        n_step      = r_step;
        n_ptr       = r_ptr;
        n_out_valid = 1'b0;
        n_neg       = r_neg;
        n_q         = r_q;
        n_rem       = r_rem;
        n_char      = r_char;
        n_ok        = r_ok;
        n_last      = r_last;
        w_stack_we    = 1'b0;
        w_alpha_raddr = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cmd == sirad_pkg::CMD_CONVERT)) begin
                    n_seen = '0;
                    n_idx  = '0;
                    n_step = '0;
                    n_ptr  = '0;
                    n_rem  = '0;
                    n_q    = w_mag;
                    n_neg  = w_num[sirad_pkg::NUM_W-1];
                    if (w_len_bad) begin
                        n_out_valid = 1'b1;
                        n_char      = sirad_pkg::CHAR_NONE;
                        n_ok        = 1'b0;
                        n_last      = 1'b1;
                    end else begin
                        n_state = ST_CHK_RD;
                    end
                end
            end
            ST_CHK_RD: begin
                n_state = ST_CHK_EV;
            end
            ST_CHK_EV: begin
                if (w_sym_bad) begin
                    n_out_valid = 1'b1;
                    n_char      = sirad_pkg::CHAR_NONE;
                    n_ok        = 1'b0;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_seen[w_alpha_rdata[6:0]] = 1'b1;
                    if (w_last_sym) begin
                        if (r_neg) begin
                            n_out_valid = 1'b1;
                            n_char      = sirad_pkg::CHAR_MINUS;
                            n_ok        = 1'b1;
                            n_last      = 1'b0;
                        end
                        n_state = ST_DIV;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_CHK_RD;
                    end
                end
            end
            ST_DIV: begin
                n_q    = w_div_q;
                n_rem  = w_div_rem;
                n_step = r_step + 1'b1;
                if (r_step == sirad_pkg::STEP_W'(sirad_pkg::DIV_STEPS - 1)) begin
                    // digit done: push it, then go on while the quotient is nonzero
                    w_stack_we = 1'b1;
                    n_rem      = '0;
                    n_step     = '0;
                    if (w_div_q == '0) begin
                        n_state = ST_OUT_A;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            ST_OUT_A: begin
                n_state = ST_OUT_B;
            end
            ST_OUT_B: begin
                w_alpha_raddr = sirad_pkg::SYM_AW'(w_stack_rdata);
                n_state       = ST_OUT_C;
            end
            ST_OUT_C: begin
                n_out_valid = 1'b1;
                n_char      = w_alpha_rdata;
                n_ok        = 1'b1;
                n_last      = (r_ptr == '0);
                if (r_ptr == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = ST_OUT_A;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_base_length <= '0;
            r_idx         <= '0;
            r_seen        <= '0;
            r_step        <= '0;
            r_ptr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_seen      <= n_seen;
            r_step      <= n_step;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_base_length_we) begin
                r_base_length <= i_base_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_char <= n_char;
        r_ok   <= n_ok;
        r_last <= n_last;
    end

    assign o_result_valid = r_out_valid;
    assign o_char_code    = r_char;
    assign o_base_ok      = r_ok;
    assign o_last         = r_last;

    // a rejected alphabet always ends the item
    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_base_ok |-> o_last)
        else $error("rejected result without last");

    // a load item never makes the block busy
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == sirad_pkg::CMD_LOAD) |=> !busy)
        else $error("load item left the block busy");

    // every pass through the emit state produces a result
    a_emit_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT_C |=> o_result_valid)
        else $error("emit state without result strobe");

    // divider step count only advances inside the divide loop
    a_step_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != '0 |-> r_state == ST_DIV)
        else $error("divider step count outside divide state");

endmodule

// ===== tb/sv/tb_signed_integer_to_radix_digits_core.sv =====
typedef struct packed {
    logic [7:0] char_code;
    logic       base_ok;
    logic       last;
} t_radix_char;

class radix_digit_scoreboard;
    logic [sirad_pkg::CHAR_W-1:0] alphabet [sirad_pkg::MAX_SYMBOLS];
    logic [sirad_pkg::LEN_W-1:0]  sym_count;
    t_radix_char                  expected_chars [$];
    int unsigned                  errors;

    function new();
        foreach (alphabet[k]) alphabet[k] = '0;
        sym_count = '0;
        errors    = 0;
    endfunction

    function void set_base(logic [sirad_pkg::LEN_W-1:0] len);
        sym_count = len;
    endfunction

    function int unsigned pending();
        return expected_chars.size();
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    function void push_char(logic [7:0] ch, logic ok, logic last);
        t_radix_char c;
        c.char_code = ch;
        c.base_ok   = ok;
        c.last      = last;
        expected_chars.push_back(c);
    endfunction

    // symbols must be printable, no sign characters, all distinct
    function bit alphabet_valid();
        bit         seen [256];
        logic [7:0] c;
        foreach (seen[k]) seen[k] = 1'b0;
        if (sym_count < sirad_pkg::MIN_BASE || sym_count > sirad_pkg::MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < int'(sym_count); i++) begin
            c = alphabet[i];
            if (c == sirad_pkg::CHAR_PLUS || c == sirad_pkg::CHAR_MINUS) return 1'b0;
            if (c < sirad_pkg::CHAR_LOW || c > sirad_pkg::CHAR_HIGH) return 1'b0;
            if (seen[c]) return 1'b0;
            seen[c] = 1'b1;
        end
        return 1'b1;
    endfunction

    task predict_item(logic cmd, logic [6:0] idx, logic [7:0] code, logic [31:0] num);
        logic [31:0] mag;
        int unsigned radix;
        logic [6:0]  digits [32];
        int          depth;
        if (cmd == sirad_pkg::CMD_LOAD) begin
            alphabet[idx] = code;
            return;
        end
        if (!alphabet_valid()) begin
            push_char(sirad_pkg::CHAR_NONE, 1'b0, 1'b1);
            return;
        end
        radix = 32'(sym_count);
        if (num[31]) begin
            mag = 32'd0 - num;
            push_char(sirad_pkg::CHAR_MINUS, 1'b1, 1'b0);
        end else begin
            mag = num;
        end
        depth = 0;
        do begin
            digits[depth] = 7'(mag % radix);
            mag = mag / radix;
            depth++;
        end while (mag != 0 && depth < 32);
        for (int d = depth - 1; d >= 0; d--)
            push_char(alphabet[digits[d]], 1'b1, d == 0);
    endtask

    task check_char(logic [7:0] ch, logic ok, logic last);
        t_radix_char want;
        if (expected_chars.size() == 0) begin
            report($sformatf("unexpected char %0d ok=%0b last=%0b", ch, ok, last));
            return;
        end
        want = expected_chars.pop_front();
        if (ok !== want.base_ok)
            report($sformatf("base_ok %0b, want %0b", ok, want.base_ok));
        // the char field carries nothing on a rejected alphabet
        if (want.base_ok && ch !== want.char_code)
            report($sformatf("char_code %0d, want %0d", ch, want.char_code));
        if (last !== want.last)
            report($sformatf("last %0b, want %0b", last, want.last));
    endtask

    task flag_leftovers();
        if (expected_chars.size() != 0)
            report($sformatf("%0d chars never arrived", expected_chars.size()));
    endtask
endclass

module tb_signed_integer_to_radix_digits_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_VALID    = sirad_pkg::CHAR_HIGH - sirad_pkg::CHAR_LOW - 1;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned ITEM_TARGET  = 410;

    logic                                i_clk;
    logic                                i_rst_n          = 1'b0;
    logic                                start            = 1'b0;
    logic                                busy;
    logic                                i_base_length_we = 1'b0;
    logic [sirad_pkg::LEN_W-1:0]         i_base_length    = '0;
    logic                                i_cmd            = sirad_pkg::CMD_LOAD;
    logic [sirad_pkg::SYM_AW-1:0]        i_symbol_index   = '0;
    logic [sirad_pkg::CHAR_W-1:0]        i_symbol_code    = '0;
    logic signed [sirad_pkg::NUM_W-1:0]  i_number         = '0;
    logic                                o_result_valid;
    logic [sirad_pkg::CHAR_W-1:0]        o_char_code;
    logic                                o_base_ok;
    logic                                o_last;

    radix_digit_scoreboard        sb;
    logic [sirad_pkg::CHAR_W-1:0] valid_codes [NUM_VALID];
    int unsigned                  n_items = 0;
    int unsigned                  quiet_cycles = 0;
    bit                           no_gaps = 1'b0;

    signed_integer_to_radix_digits_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_base_length_we (i_base_length_we),
        .i_base_length    (i_base_length),
        .i_cmd            (i_cmd),
        .i_symbol_index   (i_symbol_index),
        .i_symbol_code    (i_symbol_code),
        .i_number         (i_number),
        .o_result_valid   (o_result_valid),
        .o_char_code      (o_char_code),
        .o_base_ok        (o_base_ok),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_char(o_char_code, o_base_ok, o_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_base_length_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_signed_integer_to_radix_digits_core: done, errors");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [sirad_pkg::NUM_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return '1;
            4:       return $urandom_range(0, 40);
            5:       return 32'd0 - $urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [sirad_pkg::SYM_AW-1:0] idx,
                             input logic [sirad_pkg::CHAR_W-1:0] code,
                             input logic [sirad_pkg::NUM_W-1:0] num);
        int unsigned gap;
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_symbol_index <= idx;
        i_symbol_code  <= code;
        i_number       <= num;
        do @(posedge i_clk); while (busy);
        sb.predict_item(cmd, idx, code, num);
        n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every expected char is out and the core is idle
    task automatic settle();
        if (start) start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [sirad_pkg::LEN_W-1:0] len);
        settle();
        i_base_length_we <= 1'b1;
        i_base_length    <= len;
        @(posedge i_clk);
        i_base_length_we <= 1'b0;
        sb.set_base(len);
    endtask

    task automatic load_shuffled(input int unsigned len);
        logic [sirad_pkg::CHAR_W-1:0] pool [NUM_VALID];
        logic [sirad_pkg::CHAR_W-1:0] tmp;
        int unsigned                  j;
        foreach (pool[k]) pool[k] = valid_codes[k];
        for (int unsigned i = 0; i < len; i++) begin
            j = $urandom_range(i, NUM_VALID - 1);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
            send_item(sirad_pkg::CMD_LOAD, sirad_pkg::SYM_AW'(i), pool[i], $urandom);
        end
    endtask

    task automatic corrupt_entry(input int unsigned len);
        int unsigned                  n;
        int unsigned                  idx;
        int unsigned                  other;
        logic [sirad_pkg::CHAR_W-1:0] code;
        n = (len > sirad_pkg::MAX_SYMBOLS) ? sirad_pkg::MAX_SYMBOLS : len;
        if (n == 0) return;
        idx = $urandom_range(0, n - 1);
        case ($urandom_range(0, 4))
            0: code = sirad_pkg::CHAR_PLUS;
            1: code = sirad_pkg::CHAR_MINUS;
            2: code = sirad_pkg::CHAR_W'($urandom_range(0, sirad_pkg::CHAR_LOW - 1));
            3: code = sirad_pkg::CHAR_W'($urandom_range(sirad_pkg::CHAR_HIGH + 1, 255));
            default: begin
                if (n < 2) begin
                    code = sirad_pkg::CHAR_PLUS;
                end else begin
                    other = (idx + 1 + $urandom_range(0, n - 2)) % n;
                    code = sb.alphabet[other];
                end
            end
        endcase
        send_item(sirad_pkg::CMD_LOAD, sirad_pkg::SYM_AW'(idx), code, $urandom);
    endtask

    initial begin
        int unsigned n;
        int unsigned r;
        int unsigned len;
        sb = new();
        n = 0;
        for (int c = sirad_pkg::CHAR_LOW; c <= sirad_pkg::CHAR_HIGH; c++) begin
            if (c != sirad_pkg::CHAR_PLUS && c != sirad_pkg::CHAR_MINUS) begin
                valid_codes[n] = sirad_pkg::CHAR_W'(c);
                n++;
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every entry gets written before any convert can read it
        for (int unsigned i = 0; i < sirad_pkg::MAX_SYMBOLS; i++)
            send_item(sirad_pkg::CMD_LOAD, sirad_pkg::SYM_AW'(i),
                      (i < NUM_VALID) ? valid_codes[i]
                                      : sirad_pkg::CHAR_W'($urandom_range(0, 255)),
                      $urandom);

        // fewer than two symbols
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd5);
        write_base(1);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd7);
        // binary: zero, most negative gives the longest run of chars, most positive
        write_base(2);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd0);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'h8000_0000);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'h7fff_ffff);
        write_base(10);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'hffff_ffff);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd1234567890);
        // sign characters, unprintable codes and a repeat in the alphabet
        send_item(sirad_pkg::CMD_LOAD, 3, sirad_pkg::CHAR_PLUS, 0);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd99);
        send_item(sirad_pkg::CMD_LOAD, 3, sirad_pkg::CHAR_MINUS, 0);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd99);
        send_item(sirad_pkg::CMD_LOAD, 3, sirad_pkg::CHAR_W'(sirad_pkg::CHAR_LOW - 1), 0);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd99);
        send_item(sirad_pkg::CMD_LOAD, 3, sirad_pkg::CHAR_W'(sirad_pkg::CHAR_HIGH + 1), 0);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd99);
        send_item(sirad_pkg::CMD_LOAD, 3, valid_codes[7], 0);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd99);
        send_item(sirad_pkg::CMD_LOAD, 3, valid_codes[3], 0);
        // widest valid alphabet runs from space to tilde
        write_base(sirad_pkg::LEN_W'(NUM_VALID));
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'h8000_0001);
        write_base(sirad_pkg::LEN_W'(sirad_pkg::MAX_SYMBOLS));
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd12345);
        write_base(8'hff);
        send_item(sirad_pkg::CMD_CONVERT, 0, 0, 32'd12345);

        while (n_items < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 65)      len = $urandom_range(2, 16);
            else if (r < 77) len = $urandom_range(17, NUM_VALID);
            else if (r < 85) len = $urandom_range(0, 1);
            else if (r < 95) len = $urandom_range(NUM_VALID + 1, 255);
            else             len = NUM_VALID;
            no_gaps = ($urandom_range(0, 3) == 0);
            if (len >= 2 && len <= NUM_VALID && $urandom_range(0, 1) == 1)
                load_shuffled(len);
            if ($urandom_range(0, 4) == 0)
                corrupt_entry(len);
            write_base(sirad_pkg::LEN_W'(len));
            repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(sirad_pkg::CMD_LOAD,
                              sirad_pkg::SYM_AW'($urandom_range(0, sirad_pkg::MAX_SYMBOLS - 1)),
                              sirad_pkg::CHAR_W'($urandom_range(0, 255)), $urandom);
                else
                    send_item(sirad_pkg::CMD_CONVERT,
                              sirad_pkg::SYM_AW'($urandom_range(0, sirad_pkg::MAX_SYMBOLS - 1)),
                              sirad_pkg::CHAR_W'($urandom_range(0, 255)), pick_number());
            end
        end
        no_gaps = 1'b0;

        settle();
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("tb_signed_integer_to_radix_digits_core: done, clean");
        else
            $display("tb_signed_integer_to_radix_digits_core: done, errors");
        $finish;
    end
endmodule
